@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. All expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, live through reset
`define ASSERT_ALWAYS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/rds_pkg.sv @@
// ----------------------------------------------------------------------------
// rds_pkg
// Types and constants shared by the 2x2 RGB downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package rds_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 2048;
  localparam int DEFAULT_MAX_HEIGHT = 2048;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_WIDTH  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;

  localparam int QUEUE_DEPTH = 4;
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } result_t;

  // horizontal pair sums, one per channel
  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } sums_t;

  typedef struct packed {
    sums_t line;
    sums_t pair;
    logic  last;
  } job_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               empty;
  } queue_stat_t;

endpackage

`default_nettype wire

@@ hdl/rds_ram.sv @@
// ----------------------------------------------------------------------------
// rds_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/rds_front.sv @@
// ----------------------------------------------------------------------------
// rds_front
// Config registers, raster position, pair sums and line store access.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_front import rds_pkg::*; #(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  input  wire pixel_t                 in_data,
  output logic                        in_stall,
  input  wire queue_stat_t            queue_stat,
  output logic                        push,
  output job_t                        push_job
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int SWW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam int SWH = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;
  localparam int LD  = MAX_WIDTH / 2;
  localparam int AW  = $clog2(LD);

  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic [CW-1:0]         col_cnt;
  logic [RW-1:0]         row_cnt;
  pixel_t                left_pixel;
  logic                  s1_valid;
  sums_t                 s1_pair;
  logic                  s1_last;

  logic [SWW-1:0] wide_w;
  logic [SWH-1:0] wide_h;
  logic [CW-1:0]  w_eff;
  logic [RW-1:0]  h_eff;
  logic [CW-1:0]  col_cur;
  logic [RW-1:0]  row_tmp;
  logic [RW-1:0]  row_cur;
  logic [CW-1:0]  col_inc;
  logic [RW-1:0]  row_inc;
  logic [CW-1:0]  col_cnt_next;
  logic [RW-1:0]  row_cnt_next;
  logic [CW-1:0]  last_col;
  logic [RW-1:0]  last_row;
  logic [CW-2:0]  col_half;
  logic           idx_ok;
  logic [AW-1:0]  addr;
  logic           accept;
  logic           ram_we;
  logic           ram_re;
  sums_t          pair_sum;
  logic [$bits(sums_t)-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_IMAGE_WIDTH;
      image_height <= RESET_IMAGE_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp sizes to 2..MAX
  always_comb begin
    wide_w = SWW'(image_width);
    wide_h = SWH'(image_height);
    if (wide_w < SWW'(2)) begin
      w_eff = CW'(2);
    end else if (wide_w > SWW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = wide_w[CW-1:0];
    end
    if (wide_h < SWH'(2)) begin
      h_eff = RW'(2);
    end else if (wide_h > SWH'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = wide_h[RW-1:0];
    end
  end

  // position of this pixel and of the next one
  always_comb begin
    if (col_cnt >= w_eff) begin
      col_cur = '0;
      row_tmp = row_cnt + RW'(1);
    end else begin
      col_cur = col_cnt;
      row_tmp = row_cnt;
    end
    row_cur = (row_tmp >= h_eff) ? '0 : row_tmp;
    col_inc = col_cur + CW'(1);
    row_inc = row_cur + RW'(1);
    if (col_inc >= w_eff) begin
      col_cnt_next = '0;
      row_cnt_next = (row_inc >= h_eff) ? '0 : row_inc;
    end else begin
      col_cnt_next = col_inc;
      row_cnt_next = row_cur;
    end
  end

  assign last_col = {w_eff[CW-1:1], 1'b0} - CW'(1);
  assign last_row = {h_eff[RW-1:1], 1'b0} - RW'(1);
  assign col_half = col_cur[CW-1:1];
  assign idx_ok   = col_half < (CW-1)'(LD);
  assign addr     = col_half[AW-1:0];

  assign in_stall = ({1'b0, queue_stat.level} + (LEVEL_W+1)'(s1_valid))
                    >= (LEVEL_W+1)'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  assign pair_sum.red   = {1'b0, left_pixel.red_in}   + {1'b0, in_data.red_in};
  assign pair_sum.green = {1'b0, left_pixel.green_in} + {1'b0, in_data.green_in};
  assign pair_sum.blue  = {1'b0, left_pixel.blue_in}  + {1'b0, in_data.blue_in};

  assign ram_we = accept && col_cur[0] && !row_cur[0] && idx_ok;
  assign ram_re = accept && col_cur[0] && row_cur[0] && idx_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt    <= '0;
      row_cnt    <= '0;
      left_pixel <= '0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= ram_re;
      if (accept) begin
        col_cnt <= col_cnt_next;
        row_cnt <= row_cnt_next;
        if (!col_cur[0]) begin
          left_pixel <= in_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_pair <= pair_sum;
      s1_last <= (col_cur == last_col) && (row_cur == last_row);
    end
  end

  rds_ram #(
    .WIDTH($bits(sums_t)),
    .DEPTH(LD)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata(pair_sum),
    .re   (ram_re),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  assign push          = s1_valid;
  assign push_job.line = sums_t'(ram_rdata);
  assign push_job.pair = s1_pair;
  assign push_job.last = s1_last;

endmodule

`default_nettype wire

@@ hdl/rds_fifo.sv @@
// ----------------------------------------------------------------------------
// rds_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_fifo import rds_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire job_t  push_job,
  input  wire logic  pop,
  output job_t       head_job,
  output queue_stat_t queue_stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t               q [QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [LEVEL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + LEVEL_W'(1);
        2'b01:   level <= level - LEVEL_W'(1);
        default: level <= level;
      endcase
    end
  end

  assign head_job         = q[rd_ptr];
  assign queue_stat.level = level;
  assign queue_stat.empty = (level == '0);

endmodule

`default_nettype wire

@@ hdl/rds_back.sv @@
// ----------------------------------------------------------------------------
// rds_back
// Block averaging and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_back import rds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire queue_stat_t queue_stat,
  input  wire job_t        head_job,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output result_t          out_data
);

  logic [9:0] red_sum;
  logic [9:0] green_sum;
  logic [9:0] blue_sum;

  assign pop = !queue_stat.empty && (!out_valid || !out_stall);

  assign red_sum   = {1'b0, head_job.line.red}   + {1'b0, head_job.pair.red};
  assign green_sum = {1'b0, head_job.line.green} + {1'b0, head_job.pair.green};
  assign blue_sum  = {1'b0, head_job.line.blue}  + {1'b0, head_job.pair.blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.red_out    <= red_sum[9:2];
      out_data.green_out  <= green_sum[9:2];
      out_data.blue_out   <= blue_sum[9:2];
      out_data.frame_last <= head_job.last;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rgb_downsample_2x2_average.sv @@
// ----------------------------------------------------------------------------
// rgb_downsample_2x2_average: 2x2 box-filter downsampler for RGB pixels
// A job from each odd-row, odd-column pixel passes the line store read
// register, job queue and output register. Throughput: one pixel per cycle;
// input stalls only behind a stalled result, when jobs fill the 4-entry queue.
// Reset: rst sync high; sizes 640x480, position and queue cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_downsample_2x2_average import rds_pkg::*; #(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire pixel_t                 in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output result_t                     out_data
);

  queue_stat_t queue_stat;
  logic        push;
  job_t        push_job;
  logic        pop;
  job_t        head_job;

  rds_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .queue_stat(queue_stat),
    .push      (push),
    .push_job  (push_job)
  );

  rds_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_job  (head_job),
    .queue_stat(queue_stat)
  );

  rds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .queue_stat(queue_stat),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ hdl/rds_checker.sv @@
// ----------------------------------------------------------------------------
// rds_checker
// Port-level checks for the 2x2 RGB downsampler.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rds_checker import rds_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    in_valid,
  input wire logic    in_stall,
  input wire logic    out_valid,
  input wire logic    out_stall,
  input wire result_t out_data
);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `ASSERT_ALWAYS_NEXT(a_reset_idle, rst, !out_valid)
  // a fresh result must trace back to an accepted input pixel
  `ASSERT_NOW(a_rise_latency, $rose(out_valid), $past(in_valid && !in_stall, 3))
  // input backs up only behind a waiting result
  `ASSERT_NOW(a_stall_cause, in_stall, out_valid)

endmodule

bind rgb_downsample_2x2_average rds_checker u_checker (.*);

`default_nettype wire
